>>> src/hbec_pkg.sv
// ----------------------------------------------------------------------------
// Hamming byte encode/correct package
// Shared types, codes and bit-placement functions for the single-error
// correcting code over one data byte.
// ----------------------------------------------------------------------------
package hbec_pkg;

  localparam int unsigned CODE_W = 14;
  localparam int unsigned DATA_W = 8;
  localparam int unsigned SYN_W  = 4;
  localparam int unsigned STAT_W = 2;
  localparam logic [SYN_W-1:0] TOP_POS = 4'd13;

  localparam logic KIND_ENCODE = 1'b0;
  localparam logic KIND_DECODE = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_FIXED   = 2'd1;
  localparam logic [STAT_W-1:0] ST_UNCORR  = 2'd2;

  typedef logic [CODE_W-1:0] code_t;
  typedef logic [DATA_W-1:0] data_t;
  typedef logic [SYN_W-1:0]  syn_t;
  typedef logic [STAT_W-1:0] stat_t;

  typedef logic [SYN_W-1:0] pos_array_t [DATA_W];
  localparam pos_array_t DATA_POS = '{4'd3, 4'd5, 4'd6, 4'd7, 4'd9, 4'd10, 4'd11, 4'd12};

  typedef struct packed {
    logic  kind;
    data_t data_byte;
    code_t code_in;
  } item_t;

  typedef struct packed {
    code_t code_out;
    data_t data_out;
    stat_t status;
    syn_t  syndrome;
  } result_t;

  function automatic code_t place_data(data_t b);
    code_t w;
    w = '0;
    for (int k = 0; k < DATA_W; k++) begin
      w[DATA_POS[k]] = b[k];
    end
    return w;
  endfunction

  function automatic data_t take_data(code_t w);
    data_t b;
    for (int k = 0; k < DATA_W; k++) begin
      b[k] = w[DATA_POS[k]];
    end
    return b;
  endfunction

  function automatic syn_t syndrome_of(code_t w);
    syn_t s;
    s = '0;
    for (int i = 1; i < CODE_W; i++) begin
      if (w[i]) begin
        s = s ^ SYN_W'(i);
      end
    end
    return s;
  endfunction

endpackage

>>> src/hbec_if.sv
// ----------------------------------------------------------------------------
// Hamming byte encode/correct channels
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface hbec_in_if;
  logic           valid;
  logic           ready;
  logic           kind;
  hbec_pkg::data_t data_byte;
  hbec_pkg::code_t code_in;

  modport source (output valid, output kind, output data_byte, output code_in, input ready);
  modport sink   (input valid, input kind, input data_byte, input code_in, output ready);
endinterface

interface hbec_out_if;
  logic            valid;
  logic            ready;
  hbec_pkg::code_t code_out;
  hbec_pkg::data_t data_out;
  hbec_pkg::stat_t status;
  hbec_pkg::syn_t  syndrome;

  modport source (output valid, output code_out, output data_out, output status,
                  output syndrome, input ready);
  modport sink   (input valid, input code_out, input data_out, input status,
                  input syndrome, output ready);
endinterface

>>> src/hamming_byte_encode_correct.sv
// ----------------------------------------------------------------------------
// Hamming byte encode/correct
// Encodes a data byte into a 14-bit single-error-correcting codeword, or
// decodes a codeword, correcting one flipped bit from its syndrome.
// ----------------------------------------------------------------------------
// Each item is captured in an input register, passes through the encode or
// decode logic, and lands in a result register, from which it is offered on
// the output; the result register loads when it is empty or being emptied.
// While the receiver takes results, one item can be taken every cycle.
// While a result waits on a stalled receiver the input register still
// takes one more item; after that the input stalls until the result is taken.
module hamming_byte_encode_correct (
  input  logic        clk,
  input  logic        rst_n,
  hbec_in_if.sink     in_ch,
  hbec_out_if.source  out_ch
);

  logic              in_valid_r;
  hbec_pkg::item_t   item_r;
  logic              out_valid_r;
  hbec_pkg::result_t res_r;
  hbec_pkg::result_t res_nxt;
  logic              out_load;

  hbec_core u_core (
    .item (item_r),
    .res  (res_nxt)
  );

  assign out_load    = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || out_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        in_valid_r <= in_ch.valid;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item_r.kind      <= in_ch.kind;
      item_r.data_byte <= in_ch.data_byte;
      item_r.code_in   <= in_ch.code_in;
    end
    if (out_load) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.code_out = res_r.code_out;
  assign out_ch.data_out = res_r.data_out;
  assign out_ch.status   = res_r.status;
  assign out_ch.syndrome = res_r.syndrome;

endmodule

>>> src/hbec_core.sv
// ----------------------------------------------------------------------------
// Hamming byte encode/correct datapath
// Combinational encoder and syndrome decoder with single-bit correction.
// ----------------------------------------------------------------------------
module hbec_core (
  input  hbec_pkg::item_t   item,
  output hbec_pkg::result_t res
);

  hbec_pkg::code_t enc_w;
  hbec_pkg::syn_t  enc_s;
  hbec_pkg::code_t dec_w;
  hbec_pkg::syn_t  dec_s;
  hbec_pkg::stat_t dec_st;

  always_comb begin
    enc_w = hbec_pkg::place_data(item.data_byte);
    enc_s = hbec_pkg::syndrome_of(enc_w);
    for (int j = 0; j < hbec_pkg::SYN_W; j++) begin
      enc_w[1 << j] = enc_s[j];
    end
    enc_w[0] = ^enc_w[hbec_pkg::CODE_W-1:1];
  end

  always_comb begin
    dec_s = hbec_pkg::syndrome_of(item.code_in);
    dec_w = item.code_in;
    if (dec_s == '0) begin
      dec_st = hbec_pkg::ST_OK;
    end else if (dec_s <= hbec_pkg::TOP_POS) begin
      dec_w  = item.code_in ^ (hbec_pkg::code_t'(1) << dec_s);
      dec_st = hbec_pkg::ST_FIXED;
    end else begin
      dec_st = hbec_pkg::ST_UNCORR;
    end
  end

  always_comb begin
    if (item.kind == hbec_pkg::KIND_DECODE) begin
      res.code_out = dec_w;
      res.data_out = hbec_pkg::take_data(dec_w);
      res.status   = dec_st;
      res.syndrome = dec_s;
    end else begin
      res.code_out = enc_w;
      res.data_out = item.data_byte;
      res.status   = hbec_pkg::ST_OK;
      res.syndrome = '0;
    end
  end

endmodule
